>>> rtl/dlfd_pkg.sv
// dlfd_pkg: shared types and constants of the delta line frame decoder
// used by every module under rtl/, no dependencies
`default_nettype none

package dlfd_pkg;

  // address bits kept on the pixel address before it is cut to the port width
  localparam int ADDR_BITS = 20;
  localparam int PIX_ADDR_W = 20;
  localparam int TRUE_ADDR_W = 28;
  localparam logic [TRUE_ADDR_W-1:0] ADDR_MASK =
    TRUE_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd200;
  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ZERO = 2'd3;

  // opcode kinds, top two bits of an opcode word
  localparam logic [1:0] OP_PACKETS = 2'd0;
  localparam logic [1:0] OP_IGNORED = 2'd1;
  localparam logic [1:0] OP_LAST_PIXEL = 2'd2;
  localparam logic [1:0] OP_SKIP_LINES = 2'd3;

  typedef enum logic [3:0] {
    PH_LC_LO   = 4'd0,
    PH_LC_HI   = 4'd1,
    PH_OP_LO   = 4'd2,
    PH_OP_HI   = 4'd3,
    PH_SKIP    = 4'd4,
    PH_COUNT   = 4'd5,
    PH_DATA_LO = 4'd6,
    PH_DATA_HI = 4'd7,
    PH_FILL_LO = 4'd8,
    PH_FILL_HI = 4'd9
  } phase_t;

  // one queue entry: an optional write followed by an optional chunk end
  typedef struct packed {
    logic        wr_valid;
    logic        wr_fill;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] value;
    logic [7:0]  fill;
    logic        end_valid;
    logic        end_zero;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/delta_line_frame_decoder_core.sv
// delta_line_frame_decoder_core: top level of the word-delta chunk decoder
// depends on dlfd_pkg, dlfd_front, dlfd_queue, dlfd_back
//
// Usage:
//   in_*   one payload byte per word: in_tdata[7:0] is the byte, in_tuser
//          is high on the first byte of a chunk.
//   out_*  frame-buffer results; out_tuser is the result kind (byte write,
//          fill run, chunk done, ended by zero count), out_tlast marks the
//          last result caused by one input byte.
//   cfg_*  frame_width at index 0, frame_height at index 1; write only
//          while no byte is in flight.
// Results go through queue, multiply stage and output register. Throughput:
//   one byte per cycle while the queue is not full; the parser handles each
//   byte in the cycle it is accepted. The output register sends one result
//   per cycle while out_tready is high; a write with a chunk end makes two results.
// A four-entry command queue sits between parser and back end; when the
//   receiver stalls the queue fills and in_tready falls once it is full.
// Reset (rst_n low, synchronous) empties queue and pipeline, loads the
//   default 320 x 200 frame and leaves the parser idle until a chunk start.
`default_nettype none

module delta_line_frame_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] chunk_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [19:0] pixel_address, [35:20] pixel_value,
                                       // [43:36] fill_words, [44] outside_frame
  output logic [1:0]       out_tuser,  // [1:0] result_kind
  output logic             out_tlast,  // last_for_input
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata
);

  logic [dlfd_pkg::CFG_W-1:0] width_r, height_r;
  logic           accept, push, q_pop, q_not_empty, q_full;
  dlfd_pkg::cmd_t push_cmd, q_head;
  logic [dlfd_pkg::PIX_ADDR_W-1:0] pix_addr;
  logic [15:0]    pix_value;
  logic [7:0]     fill_words;
  logic           outside;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= dlfd_pkg::WIDTH_RESET;
      height_r <= dlfd_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlfd_pkg::REG_FRAME_WIDTH: width_r <= cfg_wdata;
        dlfd_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // no byte is taken while reset is held
  assign in_tready = rst_n && !q_full;
  assign accept = in_tvalid && in_tready;

  dlfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .chunk_start (in_tuser),
    .frame_width (width_r),
    .cmd         (push_cmd),
    .push        (push)
  );

  dlfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  dlfd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (width_r),
    .frame_height (height_r),
    .q_head       (q_head),
    .q_not_empty  (q_not_empty),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_tuser),
    .out_addr     (pix_addr),
    .out_value    (pix_value),
    .out_fill     (fill_words),
    .out_outside  (outside),
    .out_last     (out_tlast)
  );

  assign out_tdata = {3'd0, outside, fill_words, pix_value, pix_addr};

endmodule

`default_nettype wire

>>> rtl/dlfd_front.sv
// dlfd_front: byte parser of the word-delta chunk, keeps the parse state
// and turns each byte into at most one command; uses dlfd_pkg
`default_nettype none

module dlfd_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       chunk_start,
  input  wire logic [dlfd_pkg::CFG_W-1:0] frame_width,
  output dlfd_pkg::cmd_t                  cmd,
  output logic                            push
);

  dlfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] lines_left_r, lines_left_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] packets_r, packets_nxt;
  logic [15:0] col_r, col_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  run_r, run_nxt;
  logic        fin_r, fin_nxt;

  always_comb begin : parse
    logic [15:0] op;
    logic        pkt_end;
    logic        line_end;
    logic [15:0] last_col;
    phase_nxt = phase_r;
    lines_left_nxt = lines_left_r;
    line_nxt = line_r;
    packets_nxt = packets_r;
    col_nxt = col_r;
    held_nxt = held_r;
    run_nxt = run_r;
    fin_nxt = fin_r;
    cmd = '0;
    pkt_end = 1'b0;
    line_end = 1'b0;
    op = {data_byte, held_r};
    last_col = (frame_width == '0) ? 16'd0 : 16'(frame_width - 1'b1);

    if (chunk_start) begin
      fin_nxt = 1'b0;
      phase_nxt = dlfd_pkg::PH_LC_LO;
      line_nxt = '0;
      packets_nxt = '0;
      col_nxt = '0;
    end

    if (!fin_nxt) begin
      unique case (phase_nxt)
        dlfd_pkg::PH_LC_LO: begin
          held_nxt = data_byte;
          phase_nxt = dlfd_pkg::PH_LC_HI;
        end
        dlfd_pkg::PH_LC_HI: begin
          lines_left_nxt = op;
          if (op == 16'd0) begin
            fin_nxt = 1'b1;
            phase_nxt = dlfd_pkg::PH_LC_LO;
            cmd.end_valid = 1'b1;
          end else begin
            phase_nxt = dlfd_pkg::PH_OP_LO;
          end
        end
        dlfd_pkg::PH_OP_LO: begin
          held_nxt = data_byte;
          phase_nxt = dlfd_pkg::PH_OP_HI;
        end
        dlfd_pkg::PH_OP_HI: begin
          phase_nxt = dlfd_pkg::PH_OP_LO;
          unique case (op[15:14])
            dlfd_pkg::OP_PACKETS: begin
              packets_nxt = op;
              col_nxt = '0;
              if (op == 16'd0) line_end = 1'b1;
              else phase_nxt = dlfd_pkg::PH_SKIP;
            end
            dlfd_pkg::OP_LAST_PIXEL: begin
              cmd.wr_valid = 1'b1;
              cmd.line = line_nxt;
              cmd.col = last_col;
              cmd.value = {8'd0, op[7:0]};
            end
            dlfd_pkg::OP_SKIP_LINES: begin
              line_nxt = line_nxt - op;
            end
            dlfd_pkg::OP_IGNORED: begin
            end
            default: begin
            end
          endcase
        end
        dlfd_pkg::PH_SKIP: begin
          col_nxt = col_nxt + 16'(data_byte);
          phase_nxt = dlfd_pkg::PH_COUNT;
        end
        dlfd_pkg::PH_COUNT: begin
          if (data_byte == 8'd0) begin
            fin_nxt = 1'b1;
            phase_nxt = dlfd_pkg::PH_LC_LO;
            cmd.end_valid = 1'b1;
            cmd.end_zero = 1'b1;
          end else if (!data_byte[7]) begin
            run_nxt = data_byte;
            phase_nxt = dlfd_pkg::PH_DATA_LO;
          end else begin
            run_nxt = 8'(9'd256 - 9'(data_byte));
            phase_nxt = dlfd_pkg::PH_FILL_LO;
          end
        end
        dlfd_pkg::PH_DATA_LO, dlfd_pkg::PH_DATA_HI: begin
          cmd.wr_valid = 1'b1;
          cmd.line = line_nxt;
          cmd.col = col_nxt;
          cmd.value = {8'd0, data_byte};
          col_nxt = col_nxt + 16'd1;
          if (phase_nxt == dlfd_pkg::PH_DATA_LO) begin
            phase_nxt = dlfd_pkg::PH_DATA_HI;
          end else begin
            run_nxt = run_nxt - 8'd1;
            if (run_nxt == 8'd0) pkt_end = 1'b1;
            else phase_nxt = dlfd_pkg::PH_DATA_LO;
          end
        end
        dlfd_pkg::PH_FILL_LO: begin
          held_nxt = data_byte;
          phase_nxt = dlfd_pkg::PH_FILL_HI;
        end
        dlfd_pkg::PH_FILL_HI: begin
          cmd.wr_valid = 1'b1;
          cmd.wr_fill = 1'b1;
          cmd.line = line_nxt;
          cmd.col = col_nxt;
          cmd.value = op;
          cmd.fill = run_nxt;
          col_nxt = col_nxt + {7'd0, run_nxt, 1'b0};
          pkt_end = 1'b1;
        end
        default: begin
          phase_nxt = dlfd_pkg::PH_LC_LO;
        end
      endcase

      if (pkt_end) begin
        packets_nxt = packets_nxt - 16'd1;
        if (packets_nxt == 16'd0) line_end = 1'b1;
        else phase_nxt = dlfd_pkg::PH_SKIP;
      end

      if (line_end) begin
        line_nxt = line_nxt + 16'd1;
        lines_left_nxt = lines_left_nxt - 16'd1;
        if (lines_left_nxt == 16'd0) begin
          fin_nxt = 1'b1;
          phase_nxt = dlfd_pkg::PH_LC_LO;
          cmd.end_valid = 1'b1;
        end else begin
          phase_nxt = dlfd_pkg::PH_OP_LO;
        end
      end
    end
  end

  assign push = accept && (cmd.wr_valid || cmd.end_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dlfd_pkg::PH_LC_LO;
      lines_left_r <= '0;
      line_r <= '0;
      packets_r <= '0;
      col_r <= '0;
      held_r <= '0;
      run_r <= '0;
      fin_r <= 1'b1;
    end else if (accept) begin
      phase_r <= phase_nxt;
      lines_left_r <= lines_left_nxt;
      line_r <= line_nxt;
      packets_r <= packets_nxt;
      col_r <= col_nxt;
      held_r <= held_nxt;
      run_r <= run_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dlfd_queue.sv
// dlfd_queue: short command queue between parser and address back end
// uses dlfd_pkg for the entry type and depth
`default_nettype none

module dlfd_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire dlfd_pkg::cmd_t push_cmd,
  input  wire logic     pop,
  output dlfd_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);

  dlfd_pkg::cmd_t entries_r [dlfd_pkg::QDEPTH];
  logic [dlfd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [dlfd_pkg::QCNT_W-1:0] count_r;

  function automatic logic [dlfd_pkg::QPTR_W-1:0] bump(
    input logic [dlfd_pkg::QPTR_W-1:0] p
  );
    return (p == dlfd_pkg::QPTR_W'(dlfd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head = entries_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full = (count_r == dlfd_pkg::QCNT_W'(dlfd_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop) rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // the parser only pushes on accepted bytes, and bytes are refused when full
  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue push while full");
  assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> rtl/dlfd_back.sv
// dlfd_back: address multiply stage and output register, splits a command
// into a write and a chunk end result; uses dlfd_pkg
`default_nettype none

module dlfd_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [dlfd_pkg::CFG_W-1:0]     frame_width,
  input  wire logic [dlfd_pkg::CFG_W-1:0]     frame_height,
  input  wire dlfd_pkg::cmd_t                 q_head,
  input  wire logic                           q_not_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_kind,
  output logic [dlfd_pkg::PIX_ADDR_W-1:0]     out_addr,
  output logic [15:0]                         out_value,
  output logic [7:0]                          out_fill,
  output logic                                out_outside,
  output logic                                out_last
);

  localparam int PROD_W = 16 + dlfd_pkg::CFG_W;
  localparam int LIMIT_W = 2 * dlfd_pkg::CFG_W;

  logic [LIMIT_W-1:0] limit_r;
  logic               s1_valid_r;
  dlfd_pkg::cmd_t     s1_cmd_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic               s1_wr_sent_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [dlfd_pkg::PIX_ADDR_W-1:0] out_addr_r;
  logic [15:0]        out_value_r;
  logic [7:0]         out_fill_r;
  logic               out_outside_r;
  logic               out_last_r;

  logic out_load, sending_wr, s1_pop;
  logic [dlfd_pkg::TRUE_ADDR_W-1:0] true_addr;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign sending_wr = s1_cmd_r.wr_valid && !s1_wr_sent_r;
  assign s1_pop = out_load && (!sending_wr || !s1_cmd_r.end_valid);
  assign q_pop = q_not_empty && (!s1_valid_r || s1_pop);
  assign true_addr = dlfd_pkg::TRUE_ADDR_W'(s1_prod_r) +
                     dlfd_pkg::TRUE_ADDR_W'(s1_cmd_r.col);

  // frame size must change only while idle (not enforced here), so a running product is enough
  always_ff @(posedge clk) begin
    limit_r <= LIMIT_W'(frame_width) * LIMIT_W'(frame_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_wr_sent_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
        s1_wr_sent_r <= 1'b0;
      end else if (s1_pop) begin
        s1_valid_r <= 1'b0;
        s1_wr_sent_r <= 1'b0;
      end else if (out_load && sending_wr) begin
        s1_wr_sent_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r <= q_head;
      s1_prod_r <= PROD_W'(q_head.line) * PROD_W'(frame_width);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sending_wr) begin
        out_kind_r <= s1_cmd_r.wr_fill ? dlfd_pkg::KIND_FILL : dlfd_pkg::KIND_BYTE;
        out_addr_r <= dlfd_pkg::PIX_ADDR_W'(true_addr & dlfd_pkg::ADDR_MASK);
        out_value_r <= s1_cmd_r.value;
        out_fill_r <= s1_cmd_r.fill;
        out_outside_r <= (true_addr >= dlfd_pkg::TRUE_ADDR_W'(limit_r));
        out_last_r <= !s1_cmd_r.end_valid;
      end else begin
        out_kind_r <= s1_cmd_r.end_zero ? dlfd_pkg::KIND_ZERO : dlfd_pkg::KIND_DONE;
        out_addr_r <= '0;
        out_value_r <= '0;
        out_fill_r <= '0;
        out_outside_r <= 1'b0;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_addr = out_addr_r;
  assign out_value = out_value_r;
  assign out_fill = out_fill_r;
  assign out_outside = out_outside_r;
  assign out_last = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_cmd_r.wr_valid || s1_cmd_r.end_valid))
    else $error("empty command reached the multiply stage");
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_wr_sent_r |-> (s1_valid_r && s1_cmd_r.wr_valid && s1_cmd_r.end_valid))
    else $error("write marked sent on a command without a chunk end");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == dlfd_pkg::KIND_DONE ||
                     out_kind_r == dlfd_pkg::KIND_ZERO)) |-> out_last_r)
    else $error("chunk end result not marked last");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && sending_wr && s1_cmd_r.end_valid) |=> (s1_valid_r && s1_wr_sent_r))
    else $error("chunk end lost after its write");

endmodule

`default_nettype wire
